// ----- hw/rtl/utf8_stream_decoder_defines.svh -----
// Assertion macros shared by the UTF-8 stream decoder RTL.
// No dependencies; included inside module bodies.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define U8SD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("u8sd assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define U8SD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8sd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define U8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8sd assertion failed");

`endif

// ----- hw/rtl/u8sd_pkg.sv -----
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies.
`timescale 1ns / 1ps

package u8sd_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [30:0] code_point;
        logic        bad_sequence;
        logic        end_of_string;
    } char_item_t;

    typedef enum logic [1:0] {
        CLS_ASCII   = 2'd0,
        CLS_LEAD    = 2'd1,
        CLS_CONT    = 2'd2,
        CLS_INVALID = 2'd3
    } byte_class_t;

    // Classified byte handed from front to back.
    typedef struct packed {
        byte_class_t cls;
        logic [2:0]  extra;      // continuation bytes a lead announces
        logic [5:0]  lead_bits;  // lead payload, already masked
        logic [7:0]  data_byte;
        logic        last_byte;
    } fe_item_t;

endpackage

// ----- hw/rtl/utf8_stream_decoder.sv -----
// UTF-8 stream decoder, six-byte form: top level joining front, queue and back.
// Depends on u8sd_pkg, u8sd_front, u8sd_queue, u8sd_back.
`timescale 1ns / 1ps

// Takes one UTF-8 byte per transfer and returns one result per finished
// sequence: the code point, or an error for an invalid lead, a continuation
// byte without the 10 prefix (reported when the sequence's full length is in),
// or a string that ends mid-sequence. Sustained rate is one byte per clock
// while the output is not stalled; the decode back end updates its counter
// and accumulator once per byte. With no stall, a result's last byte passes
// from the front register, which loads at the transfer, to a queue slot and
// then to the output register, from which the result is presented. QUEUE_DEPTH
// sets the number of classified bytes buffered between front and back.
module utf8_stream_decoder #(
    parameter int QUEUE_DEPTH = u8sd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  u8sd_pkg::byte_item_t byte_item,
    output logic                 char_valid,
    input  logic                 char_ready,
    output u8sd_pkg::char_item_t char_item
);
    import u8sd_pkg::*;

    logic     fq_valid;
    logic     fq_ready;
    fe_item_t fq_item;
    logic     qb_valid;
    logic     qb_ready;
    fe_item_t qb_item;

    u8sd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item)
    );

    u8sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    u8sd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item)
    );

endmodule

// ----- hw/rtl/u8sd_front.sv -----
// Front stage: registers each incoming byte together with its class.
// Depends on u8sd_pkg.
`timescale 1ns / 1ps

module u8sd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  u8sd_pkg::byte_item_t byte_item,
    output logic                 push_valid,
    input  logic                 push_ready,
    output u8sd_pkg::fe_item_t   push_item
);
    import u8sd_pkg::*;

    logic       valid_reg;
    fe_item_t   item_reg;
    fe_item_t   item_next;
    logic       take;

    always_comb
    begin
        item_next.data_byte = byte_item.data_byte;
        item_next.last_byte = byte_item.last_byte;
        item_next.cls       = CLS_LEAD;
        item_next.extra     = 3'd0;
        case (byte_item.data_byte) inside
            [8'h00:8'h7f]: item_next.cls   = CLS_ASCII;
            [8'h80:8'hbf]: item_next.cls   = CLS_CONT;
            [8'hc0:8'hdf]: item_next.extra = 3'd1;
            [8'he0:8'hef]: item_next.extra = 3'd2;
            [8'hf0:8'hf7]: item_next.extra = 3'd3;
            [8'hf8:8'hfb]: item_next.extra = 3'd4;
            [8'hfc:8'hfd]: item_next.extra = 3'd5;
            default:       item_next.cls   = CLS_INVALID;
        endcase
        item_next.lead_bits = byte_item.data_byte[5:0] & (6'h3f >> item_next.extra);
    end

    assign byte_ready = !valid_reg || push_ready;
    assign take       = byte_valid && byte_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (byte_ready)
        begin
            valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- hw/rtl/u8sd_queue.sv -----
// Small FIFO between the classify front and the decode back.
// Depends on u8sd_pkg and utf8_stream_decoder_defines.svh.
`timescale 1ns / 1ps

module u8sd_queue #(
    parameter int DEPTH = u8sd_pkg::QUEUE_DEPTH_DEFAULT  // 2 and up
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  u8sd_pkg::fe_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output u8sd_pkg::fe_item_t pop_item
);
    import u8sd_pkg::*;
    `include "utf8_stream_decoder_defines.svh"

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    fe_item_t        slot_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            push;
    logic            pop;

    assign push_ready = count_reg != CntW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    `U8SD_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CntW'(DEPTH))

endmodule

// ----- hw/rtl/u8sd_back.sv -----
// Decode back end: sequence state, accumulator and the output register.
// Depends on u8sd_pkg and utf8_stream_decoder_defines.svh.
`timescale 1ns / 1ps

module u8sd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  u8sd_pkg::fe_item_t   pop_item,
    output logic                 char_valid,
    input  logic                 char_ready,
    output u8sd_pkg::char_item_t char_item
);
    import u8sd_pkg::*;
    `include "utf8_stream_decoder_defines.svh"

    logic [2:0]  bytes_left_reg;
    logic [2:0]  bytes_left_next;
    logic [30:0] acc_reg;
    logic [30:0] acc_next;
    logic        seen_bad_reg;
    logic        seen_bad_next;
    logic        out_valid_reg;
    char_item_t  out_reg;
    char_item_t  out_next;
    logic        emit;
    logic        pop;
    logic [30:0] acc_shift;
    logic        bad_acc;
    logic [2:0]  left_dec;

    assign pop_ready = !out_valid_reg || char_ready;
    assign pop       = pop_valid && pop_ready;
    assign acc_shift = {acc_reg[24:0], pop_item.data_byte[5:0]};
    assign bad_acc   = seen_bad_reg || (pop_item.cls != CLS_CONT);
    assign left_dec  = bytes_left_reg - 3'd1;

    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        acc_next        = acc_reg;
        seen_bad_next   = seen_bad_reg;
        emit            = 1'b0;
        out_next        = '{code_point: '0, bad_sequence: 1'b1,
                            end_of_string: pop_item.last_byte};
        if (pop)
        begin
            if (bytes_left_reg == 3'd0)
            begin
                case (pop_item.cls)
                    CLS_ASCII:
                    begin
                        emit                  = 1'b1;
                        out_next.code_point   = {24'd0, pop_item.data_byte[6:0]};
                        out_next.bad_sequence = 1'b0;
                    end
                    CLS_LEAD:
                    begin
                        if (pop_item.last_byte)
                        begin
                            emit = 1'b1;  // string ends right after a lead
                        end
                        else
                        begin
                            bytes_left_next = pop_item.extra;
                            acc_next        = {25'd0, pop_item.lead_bits};
                            seen_bad_next   = 1'b0;
                        end
                    end
                    default:
                    begin
                        emit = 1'b1;  // stray continuation or 0xfe/0xff
                    end
                endcase
            end
            else if (left_dec == 3'd0)
            begin
                emit                  = 1'b1;
                out_next.bad_sequence = bad_acc;
                out_next.code_point   = bad_acc ? '0 : acc_shift;
                bytes_left_next       = 3'd0;
                acc_next              = '0;
                seen_bad_next         = 1'b0;
            end
            else if (pop_item.last_byte)
            begin
                emit            = 1'b1;  // truncated sequence
                bytes_left_next = 3'd0;
                acc_next        = '0;
                seen_bad_next   = 1'b0;
            end
            else
            begin
                bytes_left_next = left_dec;
                acc_next        = acc_shift;
                seen_bad_next   = bad_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 3'd0;
            acc_reg        <= '0;
            seen_bad_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
            acc_reg        <= acc_next;
            seen_bad_reg   <= seen_bad_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (char_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    assign char_valid = out_valid_reg;
    assign char_item  = out_reg;

    `U8SD_ASSERT_ALWAYS(a_left_range, clk, rst_n, bytes_left_reg < 3'd6)
    `U8SD_ASSERT_SAME(a_bad_zero, clk, rst_n, out_valid_reg && out_reg.bad_sequence, out_reg.code_point == '0)
    `U8SD_ASSERT_NEXT(a_lead_load, clk, rst_n, pop && (bytes_left_reg == 3'd0) && (pop_item.cls == CLS_LEAD) && !pop_item.last_byte, bytes_left_reg == $past(pop_item.extra))

endmodule

// ----- tb/utf8_stream_decoder_tb.sv -----
// Self-checking testbench for utf8_stream_decoder: directed byte table, then random sequences.
// Depends on u8sd_pkg and the utf8_stream_decoder RTL; results are checked by a local decoder.
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;

    import u8sd_pkg::*;

    localparam int RANDOM_ITEMS   = 900;
    localparam int MAX_IDLE       = 14;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AT_RESULT = 150;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 8;

    localparam logic [7:0] ASCII_MASK = 8'h7f;
    localparam logic [7:0] LEAD_MASK  = 8'h3f;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic        known;       // expected result written into the row
        logic [30:0] code_point;
        logic        bad_sequence;
        logic        end_of_string;
    } stim_row_t;

    typedef struct packed {
        logic       known;
        char_item_t res;
    } fixed_char_t;

    localparam int DIRECTED_COUNT = 23;
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{8'h41, 1'b0, 1'b1, 31'h41, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 31'h00, 1'b0, 1'b0},
        '{8'h7f, 1'b1, 1'b1, 31'h7f, 1'b0, 1'b1},
        '{8'hff, 1'b0, 1'b1, 31'h00, 1'b1, 1'b0},   // invalid lead
        '{8'hfe, 1'b0, 1'b1, 31'h00, 1'b1, 1'b0},
        '{8'h80, 1'b0, 1'b1, 31'h00, 1'b1, 1'b0},   // stray continuation
        '{8'hbf, 1'b1, 1'b1, 31'h00, 1'b1, 1'b1},
        '{8'hc3, 1'b0, 1'b0, 31'h00, 1'b0, 1'b0},
        '{8'ha9, 1'b0, 1'b0, 31'h00, 1'b0, 1'b0},
        '{8'he2, 1'b0, 1'b0, 31'h00, 1'b0, 1'b0},
        '{8'h82, 1'b0, 1'b0, 31'h00, 1'b0, 1'b0},
        '{8'hac, 1'b0, 1'b0, 31'h00, 1'b0, 1'b0},
        '{8'hfd, 1'b0, 1'b0, 31'h00, 1'b0, 1'b0},   // six-byte form, all ones
        '{8'hbf, 1'b0, 1'b0, 31'h00, 1'b0, 1'b0},
        '{8'hbf, 1'b0, 1'b0, 31'h00, 1'b0, 1'b0},
        '{8'hbf, 1'b0, 1'b0, 31'h00, 1'b0, 1'b0},
        '{8'hbf, 1'b0, 1'b0, 31'h00, 1'b0, 1'b0},
        '{8'hbf, 1'b1, 1'b0, 31'h00, 1'b0, 1'b0},
        '{8'hc3, 1'b1, 1'b1, 31'h00, 1'b1, 1'b1},   // string ends right after lead
        '{8'hdf, 1'b0, 1'b0, 31'h00, 1'b0, 1'b0},
        '{8'h41, 1'b0, 1'b0, 31'h00, 1'b0, 1'b0},   // continuation without 10 prefix
        '{8'hf8, 1'b0, 1'b0, 31'h00, 1'b0, 1'b0},
        '{8'hff, 1'b1, 1'b1, 31'h00, 1'b1, 1'b1}    // string ends mid-sequence
    };

    logic       clk;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_ready;
    byte_item_t byte_item;
    logic       char_valid;
    logic       char_ready;
    char_item_t char_item;

    // decoder state mirrored by the checker
    logic [2:0]  dec_left = '0;
    logic [30:0] dec_acc  = '0;
    logic        dec_bad  = 1'b0;

    char_item_t  pending_chars [$];
    fixed_char_t fixed_char_q [$];
    char_item_t  decoded_char;
    char_item_t  want_char;
    fixed_char_t fixed_entry;
    int          error_count = 0;
    int          sent_count  = 0;
    bit          tx_steady   = 1'b0;
    bit          rx_steady   = 1'b0;

    utf8_stream_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic byte_class_t classify_lead(input logic [7:0] b, output logic [2:0] extra);
        extra = 3'd0;
        if (b[7] == 1'b0) return CLS_ASCII;
        if (b[7:6] == 2'b10) return CLS_CONT;
        if (b[7:5] == 3'b110) begin extra = 3'd1; return CLS_LEAD; end
        if (b[7:4] == 4'b1110) begin extra = 3'd2; return CLS_LEAD; end
        if (b[7:3] == 5'b11110) begin extra = 3'd3; return CLS_LEAD; end
        if (b[7:2] == 6'b111110) begin extra = 3'd4; return CLS_LEAD; end
        if (b[7:1] == 7'b1111110) begin extra = 3'd5; return CLS_LEAD; end
        return CLS_INVALID;
    endfunction

    // Advances the mirrored state by one byte; returns 1 when a result is due.
    function automatic bit decode_byte(input byte_item_t it, output char_item_t res);
        logic [2:0]  extra;
        byte_class_t cls;
        res = '0;
        if (dec_left == 3'd0)
        begin
            cls = classify_lead(it.data_byte, extra);
            dec_acc = '0;
            dec_bad = 1'b0;
            if (cls == CLS_ASCII)
            begin
                res = '{31'(it.data_byte & ASCII_MASK), 1'b0, it.last_byte};
                return 1'b1;
            end
            if (cls != CLS_LEAD)
            begin
                res = '{31'd0, 1'b1, it.last_byte};
                return 1'b1;
            end
            if (it.last_byte)
            begin
                res = '{31'd0, 1'b1, 1'b1};
                return 1'b1;
            end
            dec_left = extra;
            dec_acc  = 31'(it.data_byte & (LEAD_MASK >> extra));
            return 1'b0;
        end
        if (it.data_byte[7:6] != 2'b10)
            dec_bad = 1'b1;
        dec_acc  = {dec_acc[24:0], it.data_byte[5:0]};
        dec_left = dec_left - 3'd1;
        if (dec_left == 3'd0 || it.last_byte)
        begin
            if (dec_left == 3'd0 && !dec_bad)
                res = '{dec_acc, 1'b0, it.last_byte};
            else
                res = '{31'd0, 1'b1, it.last_byte};
            dec_left = '0;
            dec_acc  = '0;
            dec_bad  = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Valid is only dropped when a gap follows, so it never toggles within one step.
    task automatic send_byte(input logic [7:0] d, input logic l, input logic known,
                             input char_item_t fixed);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        fixed_char_q.push_back('{known, fixed});
        byte_valid <= 1'b1;
        byte_item  <= '{d, l};
        @(posedge clk);
        while (!byte_ready) @(posedge clk);
        sent_count++;
        if ($urandom_range(0, 24) == 0) tx_steady = !tx_steady;
    endtask

    // Mostly well-formed sequences; some noise, corrupted continuations and early string ends.
    task automatic send_sequence();
        int         pick;
        int         extra;
        int         cut;
        logic [7:0] lead;
        logic [7:0] ones;
        logic [7:0] b;
        logic       ends;
        logic       corrupt;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            send_byte(8'($urandom), $urandom_range(0, 7) == 0, 1'b0, '0);
            return;
        end
        extra   = (pick < 30) ? 0 : $urandom_range(1, 5);
        corrupt = ($urandom_range(0, 9) == 0);
        cut     = (extra > 0 && $urandom_range(0, 9) == 0) ? $urandom_range(0, extra - 1) : -1;
        ends    = ($urandom_range(0, 6) == 0);
        if (extra == 0)
            lead = {1'b0, 7'($urandom)};
        else
        begin
            ones = 8'hff;
            ones = ones << (7 - extra);
            lead = ones | (8'($urandom) & (8'hff >> (extra + 2)));
        end
        send_byte(lead, (cut == 0) || (extra == 0 && ends), 1'b0, '0);
        if (cut == 0) return;
        for (int i = 1; i <= extra; i++)
        begin
            b = {2'b10, 6'($urandom)};
            if (corrupt && $urandom_range(0, 2) == 0) b = 8'($urandom);
            send_byte(b, (cut == i) || (i == extra && ends), 1'b0, '0);
            if (cut == i) return;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && byte_valid && byte_ready)
        begin
            fixed_entry = fixed_char_q.pop_front();
            if (decode_byte(byte_item, decoded_char))
                pending_chars.push_back(fixed_entry.known ? fixed_entry.res : decoded_char);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && char_valid && char_ready)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected char transfer: code_point %h bad_sequence %b",
                       char_item.code_point, char_item.bad_sequence);
                error_count++;
            end
            else
            begin
                want_char = pending_chars.pop_front();
                if (char_item.code_point !== want_char.code_point)
                begin
                    $error("code_point: expected %h, got %h",
                           want_char.code_point, char_item.code_point);
                    error_count++;
                end
                if (char_item.bad_sequence !== want_char.bad_sequence)
                begin
                    $error("bad_sequence: expected %b, got %b",
                           want_char.bad_sequence, char_item.bad_sequence);
                    error_count++;
                end
                if (char_item.end_of_string !== want_char.end_of_string)
                begin
                    $error("end_of_string: expected %b, got %b",
                           want_char.end_of_string, char_item.end_of_string);
                    error_count++;
                end
            end
        end
    end

    // Receiver; one long hold-off lets the input side back up.
    initial
    begin : receiver
        int stall;
        int taken;
        taken      = 0;
        char_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_steady ? 0 : $urandom_range(0, MAX_IDLE);
            if (taken == HOLD_AT_RESULT) stall = LONG_HOLD;
            if (stall > 0)
            begin
                char_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            char_ready <= 1'b1;
            @(posedge clk);
            while (!char_valid) @(posedge clk);
            taken++;
            if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
        end
    end

    initial
    begin : stimulus
        int drain;
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_item  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int r = 0; r < DIRECTED_COUNT; r++)
            send_byte(DIRECTED_ROWS[r].data_byte, DIRECTED_ROWS[r].last_byte,
                      DIRECTED_ROWS[r].known,
                      '{DIRECTED_ROWS[r].code_point, DIRECTED_ROWS[r].bad_sequence,
                        DIRECTED_ROWS[r].end_of_string});
        while (sent_count < DIRECTED_COUNT + RANDOM_ITEMS)
            send_sequence();
        send_byte(8'h2e, 1'b1, 1'b0, '0);   // close the final string
        byte_valid <= 1'b0;
        @(posedge clk);
        drain = 0;
        while (pending_chars.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_chars.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_chars.size());
            error_count++;
        end
        if (error_count == 0)
            $display("utf8_stream_decoder_tb: PASS");
        else
            $display("utf8_stream_decoder_tb: FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #2ms;
        $display("utf8_stream_decoder_tb: FAIL");
        $finish;
    end

endmodule
